// ===== design/assert_macros.svh =====
// Assertion macros used by the power mode controller's dpmc_ctrl module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/dpmc_pkg.sv =====
// Types and constants of the device power mode controller.
`timescale 1ns / 1ps
package dpmc_pkg;

  localparam int unsigned DISC_W     = 18;
  localparam int unsigned ALERT_W    = 20;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned GUARD_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned DISCONNECT_START_DEF = 2000;

  localparam logic [PCT_W-1:0]   ALERT_PCT_RST     = 7'd20;
  localparam logic [PCT_W-1:0]   SHUTDOWN_PCT_RST  = 7'd40;
  localparam logic [GUARD_W-1:0] GUARD_TICKS_RST   = 16'd300;
  localparam logic [DISC_W-1:0]  TIMEOUT_TICKS_RST = 18'd180000;
  localparam logic [ALERT_W-1:0] ALERT_PERIOD_RST  = 20'd600000;

  localparam logic [DISC_W-1:0] DISC_MAX = '1;

  // Plug status codes for charger and case
  localparam logic [1:0] PLUG_UNKNOWN      = 2'd0;
  localparam logic [1:0] PLUG_CONNECTED    = 2'd1;
  localparam logic [1:0] PLUG_DISCONNECTED = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALERT_PCT     = 3'd0,
    REG_SHUTDOWN_PCT  = 3'd1,
    REG_GUARD_TICKS   = 3'd2,
    REG_TIMEOUT_TICKS = 3'd3,
    REG_ALERT_PERIOD  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic             err_data_processing;
    logic             err_accelerometer;
    logic             err_fpga_link;
    logic             err_logging;
    logic [1:0]       charger_plug;
    logic [1:0]       case_plug;
    logic             case_cover_open;
    logic [PCT_W-1:0] battery_pct;
    logic             power_button;
    logic             implant_linked;
    logic             mapping_linked;
    logic             led_burst_pending;
  } tick_t;

  typedef struct packed {
    logic       ble_off;
    logic       pmic_enable;
    logic       implant_enable;
    logic       system_off;
    logic       lid_closed_event;
    logic       low_batt_stim_trigger;
    logic [3:0] error_led_mask;
    logic       error_led_clear;
    logic       power_off_led_request;
    logic       pcm_mute_request;
  } result_t;

  typedef struct packed {
    logic [PCT_W-1:0]   alert_battery_pct;
    logic [PCT_W-1:0]   shutdown_battery_pct;
    logic [GUARD_W-1:0] button_guard_ticks;
    logic [DISC_W-1:0]  disconnect_timeout_ticks;
    logic [ALERT_W-1:0] alert_period_ticks;
  } cfg_t;

endpackage

// ===== design/dpmc_tick_if.sv =====
// Input tick channel: valid/ready with the tick payload.
`timescale 1ns / 1ps
interface dpmc_tick_if;
  logic            valid;
  logic            ready;
  dpmc_pkg::tick_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== design/dpmc_res_if.sv =====
// Result channel: valid/ready with the result payload.
`timescale 1ns / 1ps
interface dpmc_res_if;
  logic              valid;
  logic              ready;
  dpmc_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== design/dpmc_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
`timescale 1ns / 1ps
interface dpmc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dpmc_pkg::CFG_IDX_W-1:0]      index;
  logic [dpmc_pkg::CFG_DATA_W-1:0]     wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

// ===== design/dpmc_cfg_regs.sv =====
// Configuration register file of the power mode controller.
`timescale 1ns / 1ps
module dpmc_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  dpmc_cfg_if.sink        cfg,
  output dpmc_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alert_battery_pct        <= dpmc_pkg::ALERT_PCT_RST;
      regs.shutdown_battery_pct     <= dpmc_pkg::SHUTDOWN_PCT_RST;
      regs.button_guard_ticks       <= dpmc_pkg::GUARD_TICKS_RST;
      regs.disconnect_timeout_ticks <= dpmc_pkg::TIMEOUT_TICKS_RST;
      regs.alert_period_ticks       <= dpmc_pkg::ALERT_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (dpmc_pkg::reg_idx_t'(cfg.index))
        dpmc_pkg::REG_ALERT_PCT:
          regs.alert_battery_pct <= cfg.wdata[dpmc_pkg::PCT_W-1:0];
        dpmc_pkg::REG_SHUTDOWN_PCT:
          regs.shutdown_battery_pct <= cfg.wdata[dpmc_pkg::PCT_W-1:0];
        dpmc_pkg::REG_GUARD_TICKS:
          regs.button_guard_ticks <= cfg.wdata[dpmc_pkg::GUARD_W-1:0];
        dpmc_pkg::REG_TIMEOUT_TICKS:
          regs.disconnect_timeout_ticks <= cfg.wdata[dpmc_pkg::DISC_W-1:0];
        dpmc_pkg::REG_ALERT_PERIOD:
          regs.alert_period_ticks <= cfg.wdata[dpmc_pkg::ALERT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/dpmc_ctrl.sv =====
// Power mode state registers and the per-tick decision logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dpmc_ctrl #(
  parameter int unsigned DISCONNECT_START = dpmc_pkg::DISCONNECT_START_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  dpmc_pkg::tick_t   tick,
  input  dpmc_pkg::cfg_t    cfg,
  output dpmc_pkg::result_t res
);

  typedef struct packed {
    logic lid;
    logic soff;
    logic impl;
    logic pmic;
    logic ble;
  } flags_t;

  flags_t                          flags, flags_next;
  logic                            first_done, first_done_next;
  logic                            lid_seen, lid_seen_next;
  logic                            po_active, po_active_next;
  logic                            po_waited, po_waited_next;
  logic [dpmc_pkg::DISC_W-1:0]     disc, disc_next;
  logic [dpmc_pkg::ALERT_W-1:0]    alert_cd, alert_cd_next;
  logic [1:0]                      last_case, last_case_next;

  logic                            any_err;
  logic                            btn;
  logic                            very_low;
  logic                            trig;
  logic                            offled;
  logic                            mute;
  logic [dpmc_pkg::ALERT_W-1:0]    cd_load;

  assign any_err = tick.err_data_processing | tick.err_accelerometer |
                   tick.err_fpga_link | tick.err_logging;

  always_comb begin
    flags_next      = flags;
    first_done_next = first_done;
    lid_seen_next   = lid_seen;
    po_active_next  = po_active;
    po_waited_next  = po_waited;
    disc_next       = disc;
    alert_cd_next   = alert_cd;
    last_case_next  = last_case;
    trig            = 1'b0;
    offled          = 1'b0;
    mute            = 1'b0;
    btn             = 1'b0;
    very_low        = 1'b0;
    cd_load         = '0;

    if (!any_err) begin
      last_case_next = tick.case_plug;
      if (tick.charger_plug == dpmc_pkg::PLUG_CONNECTED) begin
        flags_next.ble  = 1'b1;
        flags_next.pmic = 1'b0;
        mute            = 1'b1;
        if (tick.case_plug == dpmc_pkg::PLUG_CONNECTED) begin
          if (tick.case_cover_open) begin
            lid_seen_next = 1'b0;
          end else if (!lid_seen) begin
            lid_seen_next  = 1'b1;
            flags_next.lid = 1'b1;
          end
        end
        first_done_next = 1'b0;
      end else if (tick.charger_plug == dpmc_pkg::PLUG_DISCONNECTED &&
                   last_case == tick.case_plug) begin
        flags_next.ble = 1'b0;
        if (!first_done) begin
          first_done_next = 1'b1;
        end else if (!tick.led_burst_pending) begin
          flags_next.impl = 1'b1;
          flags_next.pmic = 1'b1;
          btn = tick.power_button && !tick.mapping_linked &&
                !(disc < {2'b00, cfg.button_guard_ticks});
          very_low = tick.battery_pct < cfg.shutdown_battery_pct;
          if ((very_low || btn) && !po_active) begin
            offled          = 1'b1;
            flags_next.impl = 1'b0;
            po_waited_next  = 1'b0;
            po_active_next  = 1'b1;
          end
          if (po_active_next) begin
            if (po_waited_next) begin
              po_active_next  = 1'b0;
              disc_next       = '0;
              flags_next.pmic = 1'b0;
              flags_next.soff = 1'b1;
            end else if (!very_low && tick.implant_linked) begin
              po_active_next = 1'b0;
            end
            po_waited_next = 1'b1;
          end else begin
            if (tick.implant_linked && tick.battery_pct < cfg.alert_battery_pct) begin
              trig    = (alert_cd == '0);
              cd_load = trig ? cfg.alert_period_ticks : alert_cd;
              alert_cd_next = (cd_load == '0) ? '0 : cd_load - 1'b1;
            end else begin
              alert_cd_next = '0;
            end
            if (tick.implant_linked) begin
              disc_next = '0;
            end else if (disc != dpmc_pkg::DISC_MAX) begin
              disc_next = disc + 1'b1;
            end
            if (disc_next > cfg.disconnect_timeout_ticks) begin
              disc_next       = '0;
              offled          = 1'b1;
              flags_next.impl = 1'b0;
              po_waited_next  = 1'b0;
              po_active_next  = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      first_done <= 1'b0;
      lid_seen   <= 1'b0;
      po_active  <= 1'b0;
      po_waited  <= 1'b0;
      disc       <= dpmc_pkg::DISC_W'(DISCONNECT_START);
      alert_cd   <= '0;
      last_case  <= dpmc_pkg::PLUG_UNKNOWN;
    end else if (fire) begin
      flags      <= flags_next;
      first_done <= first_done_next;
      lid_seen   <= lid_seen_next;
      po_active  <= po_active_next;
      po_waited  <= po_waited_next;
      disc       <= disc_next;
      alert_cd   <= alert_cd_next;
      last_case  <= last_case_next;
    end
  end

  always_comb begin
    res.ble_off               = flags_next.ble;
    res.pmic_enable           = flags_next.pmic;
    res.implant_enable        = flags_next.impl;
    res.system_off            = flags_next.soff;
    res.lid_closed_event      = flags_next.lid;
    res.low_batt_stim_trigger = trig;
    res.error_led_mask        = any_err ? {tick.err_fpga_link, tick.err_accelerometer,
                                           tick.err_data_processing, 1'b1} : 4'd0;
    res.error_led_clear       = !any_err;
    res.power_off_led_request = offled;
    res.pcm_mute_request      = mute;
  end

  // system off is never withdrawn once entered
  `ASSERT_NEXT(a_soff_sticky, clk, rst, flags.soff, flags.soff)
  // an error beat leaves the flags, disconnect count, last case status and power-off state untouched
  `ASSERT_NEXT(a_err_freeze, clk, rst, fire && any_err,
               $stable(flags) && $stable(disc) && $stable(last_case) && $stable(po_active))
  // radio off and rails on never coexist
  `ASSERT_ALWAYS(a_ble_pmic_excl, clk, rst, !(flags.ble && flags.pmic))

endmodule

// ===== design/device_power_mode_controller_top.sv =====
// Top level of the device power mode controller: input and result registers.
`timescale 1ns / 1ps
// One tick beat is accepted every clock cycle unless a result waiting on res.ready
// holds the input register full. Its result beat is offered from the result
// register after passing the input register: the tick is captured in an input
// register, the mode decision is made in one pass of logic against the controller
// state, and the outcome lands in a result register that also lets the next tick
// enter while a result waits to be taken. Configuration writes take effect on the
// next cycle and are expected only while no tick is in flight.
module device_power_mode_controller_top #(
  parameter int unsigned DISCONNECT_START = dpmc_pkg::DISCONNECT_START_DEF
) (
  input logic        clk,
  input logic        rst,
  dpmc_tick_if.sink  tick,
  dpmc_res_if.source res,
  dpmc_cfg_if.sink   cfg
);

  logic              s1_valid;
  dpmc_pkg::tick_t   s1_data;
  logic              s1_go;
  logic              out_valid;
  dpmc_pkg::result_t out_data;
  dpmc_pkg::result_t core_res;
  dpmc_pkg::cfg_t    cfg_regs;

  assign s1_go      = s1_valid && (!out_valid || res.ready);
  assign tick.ready = !s1_valid || s1_go;
  assign res.valid  = out_valid;
  assign res.data   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_data <= tick.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= core_res;
    end
  end

  dpmc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  dpmc_ctrl #(
    .DISCONNECT_START (DISCONNECT_START)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_go),
    .tick (s1_data),
    .cfg  (cfg_regs),
    .res  (core_res)
  );

endmodule

// ===== bench/device_power_mode_controller_top_tb.sv =====
// Self-checking bench for the power mode controller: directed tick table, then random ticks.
`timescale 1ns / 1ps
module device_power_mode_controller_top_tb;

  localparam logic [1:0]  PLUG_UNKNOWN      = dpmc_pkg::PLUG_UNKNOWN;
  localparam logic [1:0]  PLUG_CONNECTED    = dpmc_pkg::PLUG_CONNECTED;
  localparam logic [1:0]  PLUG_DISCONNECTED = dpmc_pkg::PLUG_DISCONNECTED;
  localparam logic [1:0]  PLUG_BAD = 2'd3;
  localparam int unsigned DISC_W     = dpmc_pkg::DISC_W;
  localparam int unsigned ALERT_W    = dpmc_pkg::ALERT_W;
  localparam int unsigned CFG_DATA_W = dpmc_pkg::CFG_DATA_W;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned BEATS_PER_SET = 155;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_COMB} rx_mode_t;

  typedef struct packed {
    logic [3:0]        errs;       // data processing, accel, fpga, logging
    logic [1:0]        charger;
    logic [1:0]        cradle;
    logic              cover_open;
    logic [6:0]        batt;
    logic [3:0]        ctl;        // button, implant link, mapping, burst pending
    logic              fixed;      // use the typed result below
    dpmc_pkg::result_t want;  // ble pmic impl soff lid _ alert _ mask _ clear _ off led _ mute
  } tick_row_t;

  localparam tick_row_t DIRECTED_ROWS [22] = '{
    '{4'b1111, PLUG_DISCONNECTED, PLUG_CONNECTED, 1'b1, 7'd127, 4'b1111, 1'b1,
      13'b00000_0_1111_0_0_0},
    '{4'b0001, PLUG_CONNECTED, PLUG_CONNECTED, 1'b0, 7'd0, 4'b0000, 1'b1,
      13'b00000_0_0001_0_0_0},
    '{4'b0000, PLUG_BAD, PLUG_BAD, 1'b0, 7'd0, 4'b0000, 1'b1, 13'b00000_0_0000_1_0_0},
    '{4'b0000, PLUG_UNKNOWN, PLUG_CONNECTED, 1'b0, 7'd50, 4'b0000, 1'b1,
      13'b00000_0_0000_1_0_0},
    '{4'b0000, PLUG_CONNECTED, PLUG_CONNECTED, 1'b0, 7'd50, 4'b0000, 1'b1,
      13'b10001_0_0000_1_0_1},
    '{4'b0000, PLUG_CONNECTED, PLUG_CONNECTED, 1'b1, 7'd50, 4'b0000, 1'b1,
      13'b10001_0_0000_1_0_1},
    '{4'b0000, PLUG_CONNECTED, PLUG_CONNECTED, 1'b0, 7'd50, 4'b0000, 1'b1,
      13'b10001_0_0000_1_0_1},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_CONNECTED, 1'b0, 7'd50, 4'b0000, 1'b1,
      13'b00001_0_0000_1_0_0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd50, 4'b0000, 1'b1,
      13'b00001_0_0000_1_0_0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd100, 4'b0101, 1'b1,
      13'b00001_0_0000_1_0_0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd100, 4'b1100, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd100, 4'b1110, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd100, 4'b1000, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd39, 4'b0100, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd127, 4'b0100, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_DISCONNECTED, 1'b0, 7'd40, 4'b0000, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_BAD, 1'b0, 7'd100, 4'b0100, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_BAD, 1'b0, 7'd19, 4'b0100, 1'b0, 13'b0},
    '{4'b0010, PLUG_DISCONNECTED, PLUG_UNKNOWN, 1'b0, 7'd100, 4'b0100, 1'b0, 13'b0},
    '{4'b0000, PLUG_DISCONNECTED, PLUG_BAD, 1'b0, 7'd100, 4'b0100, 1'b0, 13'b0},
    '{4'b0000, PLUG_CONNECTED, PLUG_DISCONNECTED, 1'b1, 7'd100, 4'b1111, 1'b0, 13'b0},
    '{4'b0000, PLUG_UNKNOWN, PLUG_UNKNOWN, 1'b0, 7'd0, 4'b0000, 1'b0, 13'b0}
  };

  localparam dpmc_pkg::cfg_t CFG_PLAN [5] = '{
    '{7'd50, 7'd10, 16'd0, 18'd40, 20'd7},
    '{7'd100, 7'd0, 16'd65535, 18'd262143, 20'd1048575},
    '{7'd0, 7'd100, 16'd5, 18'd0, 20'd1},
    '{7'd90, 7'd30, 16'd20, 18'd15, 20'd0},
    '{7'd60, 7'd25, 16'd3, 18'd25, 20'd3}
  };

  logic clk = 1'b0;
  logic rst;

  dpmc_tick_if tick_ch();
  dpmc_res_if  res_ch();
  dpmc_cfg_if  cfg_ch();

  device_power_mode_controller_top dut (
    .clk (clk),
    .rst (rst),
    .tick(tick_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #2 clk = ~clk;

  // Mirror of the controller state
  dpmc_pkg::cfg_t     live_cfg;
  logic               ble_q, pmic_q, impl_q, soff_q, lid_q;
  logic               first_done, lid_seen, off_active, off_waited;
  logic [DISC_W-1:0]  unlinked_ticks;
  logic [ALERT_W-1:0] alert_wait;
  logic [1:0]         prev_cradle;

  dpmc_pkg::result_t pending_results [$];
  bit                failed = 1'b0;
  int unsigned       beats_left = 0;
  logic [1:0]        cradle_now = PLUG_CONNECTED;
  logic              link_now = 1'b1;

  function automatic dpmc_pkg::result_t predict_tick(input dpmc_pkg::tick_t t);
    dpmc_pkg::result_t r;
    logic              press;
    logic              very_low;
    r = '0;
    if (t.err_data_processing || t.err_accelerometer || t.err_fpga_link || t.err_logging) begin
      r.error_led_mask = {t.err_fpga_link, t.err_accelerometer, t.err_data_processing, 1'b1};
    end else begin
      r.error_led_clear = 1'b1;
      if (t.charger_plug == PLUG_CONNECTED) begin
        ble_q = 1'b1;
        pmic_q = 1'b0;
        r.pcm_mute_request = 1'b1;
        if (t.case_plug == PLUG_CONNECTED) begin
          if (t.case_cover_open) begin
            lid_seen = 1'b0;
          end else if (!lid_seen) begin
            lid_seen = 1'b1;
            lid_q = 1'b1;
          end
        end
        first_done = 1'b0;
      end else if (t.charger_plug == PLUG_DISCONNECTED && prev_cradle == t.case_plug) begin
        ble_q = 1'b0;
        if (!first_done) begin
          first_done = 1'b1;
        end else if (!t.led_burst_pending) begin
          impl_q = 1'b1;
          pmic_q = 1'b1;
          press = t.power_button && !t.mapping_linked &&
                  unlinked_ticks >= live_cfg.button_guard_ticks;
          very_low = t.battery_pct < live_cfg.shutdown_battery_pct;
          if ((very_low || press) && !off_active) begin
            r.power_off_led_request = 1'b1;
            impl_q = 1'b0;
            off_waited = 1'b0;
            off_active = 1'b1;
          end
          if (off_active) begin
            if (off_waited) begin
              off_active = 1'b0;
              unlinked_ticks = '0;
              pmic_q = 1'b0;
              soff_q = 1'b1;
            end else if (!very_low && t.implant_linked) begin
              off_active = 1'b0;
            end
            off_waited = 1'b1;
          end else begin
            if (t.implant_linked && t.battery_pct < live_cfg.alert_battery_pct) begin
              if (alert_wait == 0) begin
                r.low_batt_stim_trigger = 1'b1;
                alert_wait = live_cfg.alert_period_ticks;
              end
              if (alert_wait != 0) alert_wait = alert_wait - 1'b1;
            end else begin
              alert_wait = '0;
            end
            if (t.implant_linked) unlinked_ticks = '0;
            else if (unlinked_ticks != dpmc_pkg::DISC_MAX)
              unlinked_ticks = unlinked_ticks + 1'b1;
            if (unlinked_ticks > live_cfg.disconnect_timeout_ticks) begin
              unlinked_ticks = '0;
              r.power_off_led_request = 1'b1;
              impl_q = 1'b0;
              off_waited = 1'b0;
              off_active = 1'b1;
            end
          end
        end
      end
      prev_cradle = t.case_plug;
    end
    r.ble_off = ble_q;
    r.pmic_enable = pmic_q;
    r.implant_enable = impl_q;
    r.system_off = soff_q;
    r.lid_closed_event = lid_q;
    return r;
  endfunction

  // Mostly well-formed battery running with a stable cradle; the rest is noise.
  function automatic dpmc_pkg::tick_t random_tick();
    dpmc_pkg::tick_t t;
    int unsigned     pick;
    t = '0;
    if ($urandom_range(0, 24) == 0)
      {t.err_data_processing, t.err_accelerometer, t.err_fpga_link, t.err_logging} =
        4'($urandom_range(1, 15));
    pick = $urandom_range(0, 99);
    if (pick < 85) t.charger_plug = PLUG_DISCONNECTED;
    else if (pick < 92) t.charger_plug = PLUG_CONNECTED;
    else if (pick < 96) t.charger_plug = PLUG_UNKNOWN;
    else t.charger_plug = PLUG_BAD;
    if ($urandom_range(0, 19) == 0) cradle_now = 2'($urandom_range(0, 3));
    t.case_plug = cradle_now;
    t.case_cover_open = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 65) t.battery_pct = 7'($urandom_range(50, 100));
    else if (pick < 88) t.battery_pct = 7'($urandom_range(0, 49));
    else if (pick < 94) t.battery_pct = 7'($urandom_range(101, 127));
    else t.battery_pct = 7'($urandom_range(0, 127));
    t.power_button = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 11) == 0) link_now = !link_now;
    t.implant_linked = link_now;
    t.mapping_linked = ($urandom_range(0, 9) == 0);
    t.led_burst_pending = ($urandom_range(0, 9) == 0);
    return t;
  endfunction

  task automatic push_tick(input dpmc_pkg::tick_t t, input logic fixed,
                           input dpmc_pkg::result_t want);
    int unsigned gap;
    if (beats_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      beats_left = $urandom_range(1, 40);
    end
    beats_left--;
    tick_ch.valid <= 1'b1;
    tick_ch.data <= t;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    if (fixed) begin
      void'(predict_tick(t));
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(predict_tick(t));
    end
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input dpmc_pkg::cfg_t c);
    dpmc_pkg::reg_idx_t    order [5];
    logic [CFG_DATA_W-1:0] value [5];
    order = '{dpmc_pkg::REG_ALERT_PCT, dpmc_pkg::REG_SHUTDOWN_PCT,
              dpmc_pkg::REG_GUARD_TICKS, dpmc_pkg::REG_TIMEOUT_TICKS,
              dpmc_pkg::REG_ALERT_PERIOD};
    value = '{CFG_DATA_W'(c.alert_battery_pct), CFG_DATA_W'(c.shutdown_battery_pct),
              CFG_DATA_W'(c.button_guard_ticks), CFG_DATA_W'(c.disconnect_timeout_ticks),
              CFG_DATA_W'(c.alert_period_ticks)};
    foreach (order[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= order[i];
      cfg_ch.wdata <= value[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
    live_cfg = c;
  endtask

  task automatic flag_field(input string name, input int unsigned want, input int unsigned seen);
    $error("%s: expected %0d, got %0d", name, want, seen);
    failed = 1'b1;
  endtask

  task automatic compare_result(input dpmc_pkg::result_t want, input dpmc_pkg::result_t seen);
    if (seen.ble_off !== want.ble_off)
      flag_field("ble_off", want.ble_off, seen.ble_off);
    if (seen.pmic_enable !== want.pmic_enable)
      flag_field("pmic_enable", want.pmic_enable, seen.pmic_enable);
    if (seen.implant_enable !== want.implant_enable)
      flag_field("implant_enable", want.implant_enable, seen.implant_enable);
    if (seen.system_off !== want.system_off)
      flag_field("system_off", want.system_off, seen.system_off);
    if (seen.lid_closed_event !== want.lid_closed_event)
      flag_field("lid_closed_event", want.lid_closed_event, seen.lid_closed_event);
    if (seen.low_batt_stim_trigger !== want.low_batt_stim_trigger)
      flag_field("low_batt_stim_trigger", want.low_batt_stim_trigger,
                 seen.low_batt_stim_trigger);
    if (seen.error_led_mask !== want.error_led_mask)
      flag_field("error_led_mask", want.error_led_mask, seen.error_led_mask);
    if (seen.error_led_clear !== want.error_led_clear)
      flag_field("error_led_clear", want.error_led_clear, seen.error_led_clear);
    if (seen.power_off_led_request !== want.power_off_led_request)
      flag_field("power_off_led_request", want.power_off_led_request,
                 seen.power_off_led_request);
    if (seen.pcm_mute_request !== want.pcm_mute_request)
      flag_field("pcm_mute_request", want.pcm_mute_request, seen.pcm_mute_request);
  endtask

  initial begin : result_sink
    rx_mode_t          mode;
    int unsigned       mode_left;
    int unsigned       rx_cycle;
    dpmc_pkg::result_t seen;
    mode = RX_OPEN;
    mode_left = 0;
    rx_cycle = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        seen = res_ch.data;
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          failed = 1'b1;
        end else begin
          compare_result(pending_results.pop_front(), seen);
        end
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      rx_cycle++;
      case (mode)
        RX_OPEN:   res_ch.ready <= 1'b1;
        RX_RANDOM: res_ch.ready <= ($urandom_range(0, 2) != 0);
        default:   res_ch.ready <= ((rx_cycle % 5) >= 2);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    tick_row_t row;
    rst <= 1'b1;
    tick_ch.valid <= 1'b0;
    tick_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= dpmc_pkg::REG_ALERT_PCT;
    cfg_ch.wdata <= '0;
    live_cfg = '{dpmc_pkg::ALERT_PCT_RST, dpmc_pkg::SHUTDOWN_PCT_RST,
                 dpmc_pkg::GUARD_TICKS_RST, dpmc_pkg::TIMEOUT_TICKS_RST,
                 dpmc_pkg::ALERT_PERIOD_RST};
    {ble_q, pmic_q, impl_q, soff_q, lid_q} = '0;
    {first_done, lid_seen, off_active, off_waited} = '0;
    unlinked_ticks = DISC_W'(dpmc_pkg::DISCONNECT_START_DEF);
    alert_wait = '0;
    prev_cradle = PLUG_UNKNOWN;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      push_tick({row.errs, row.charger, row.cradle, row.cover_open, row.batt, row.ctl},
                row.fixed, row.want);
    end

    // reset settings first, then each planned set
    for (int s = 0; s <= $size(CFG_PLAN); s++) begin
      if (s > 0) begin
        drain();
        load_settings(CFG_PLAN[s-1]);
      end
      repeat (BEATS_PER_SET) push_tick(random_tick(), 1'b0, '0);
    end

    tick_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/dpmc_pkg.sv
design/dpmc_tick_if.sv
design/dpmc_res_if.sv
design/dpmc_cfg_if.sv
design/dpmc_cfg_regs.sv
design/dpmc_ctrl.sv
design/device_power_mode_controller_top.sv
bench/device_power_mode_controller_top_tb.sv
